// File: rtl/olst_pkg.sv
// shared types and constants of the ordered list store
`default_nettype none

package olst_pkg;

  // default list capacity and fixed field widths
  localparam int unsigned LIST_DEPTH_DEF = 32;
  localparam int unsigned CNT_W          = 6;
  localparam int unsigned ACT_W          = 3;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned POS_W          = 8;
  localparam int unsigned ST_W           = 2;

  // request codes
  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND    = 3'd0,
    ACT_DUMP      = 3'd1,
    ACT_DEL_FIRST = 3'd2,
    ACT_DEL_LAST  = 3'd3,
    ACT_DEL_AT    = 3'd4
  } action_e;

  // response status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // one response item
  typedef struct packed {
    status_e                   status;
    logic signed [VAL_W-1:0]   value;
    logic                      final_flag;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/olst_if.sv
// request and response channel interfaces of the ordered list store
`default_nettype none

interface olst_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [olst_pkg::ACT_W-1:0]           action;
  logic signed [olst_pkg::VAL_W-1:0]    item_value;
  logic signed [olst_pkg::POS_W-1:0]    position;

  modport source (output valid, action, item_value, position, input ready);
  modport sink   (input valid, action, item_value, position, output ready);
endinterface

interface olst_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [olst_pkg::ST_W-1:0]            status;
  logic signed [olst_pkg::VAL_W-1:0]    result_value;
  logic                                 final_flag;

  modport source (output valid, status, result_value, final_flag, input ready);
  modport sink   (input valid, status, result_value, final_flag, output ready);
endinterface

`default_nettype wire

// File: rtl/olst_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module olst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/ordered_list_store_with_indexed_delete_unit.sv
// top level of the ordered list store with indexed delete
//
//   channel  dir  payload                              transfer when
//   req_i    in   action, item_value, position         req_i.valid && req_i.ready
//   rsp_o    out  status, result_value, final_flag     rsp_o.valid && rsp_o.ready
//
// append, delete first on a one-element list, delete last and every error finish on
// acceptance; the result leaves through a pending slot and the output register.
// dump gives one element per cycle from the element ram while rsp_o is ready, count elements in all.
// delete first / at index shifts the tail down one entry per cycle through the ram
// read port, count - index - 1 entries once the request is accepted.
// reset clears the state, count, index, pending and output valid flags; the ram is never cleared and needs no pass.
// back-pressure on rsp_o stalls a dump in place; other requests wait in the pending slot.
`default_nettype none

module ordered_list_store_with_indexed_delete_unit #(
  parameter int unsigned LIST_DEPTH = olst_pkg::LIST_DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  olst_req_if.sink    req_i,
  olst_rsp_if.source  rsp_o
);

  localparam int unsigned AW    = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W = olst_pkg::CNT_W;
  localparam int unsigned VAL_W = olst_pkg::VAL_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DUMP  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO       = CNT_W'(2);

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic                    pend_q, pend_d;
  olst_pkg::result_t       pend_res_q, pend_res_d;
  logic                    out_valid_q, out_valid_d;
  olst_pkg::result_t       out_res_q, out_res_d;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [VAL_W-1:0]        ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [VAL_W-1:0]        ram_rdata;

  logic                    req_fire;
  logic                    out_free;
  logic                    list_empty;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    pos_ok;
  logic [CNT_W-1:0]        rm_start;
  logic [CNT_W-1:0]        rm_next;
  logic [CNT_W-1:0]        idx_p1;
  logic [CNT_W-1:0]        idx_p2;
  logic                    idx_last;
  logic                    dump_emit;

  // element storage
  olst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (LIST_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshake and helper terms
  assign req_i.ready = (state_q == S_IDLE) && !pend_q;
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign list_empty  = (cnt_q == '0);
  assign cnt_m1      = cnt_q - ONE;
  assign pos_ok      = !req_i.position[olst_pkg::POS_W-1]
                       && (req_i.position[olst_pkg::POS_W-2:0] < 7'(cnt_q));
  assign rm_start    = (olst_pkg::action_e'(req_i.action) == olst_pkg::ACT_DEL_AT)
                       ? req_i.position[CNT_W-1:0] : '0;
  assign rm_next     = rm_start + ONE;
  assign idx_p1      = idx_q + ONE;
  assign idx_p2      = idx_q + TWO;
  assign idx_last    = (idx_q == cnt_m1);
  assign dump_emit   = (state_q == S_DUMP) && out_free;

  // sequencer, list update and response staging
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_res_d  = pend_res_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = req_i.item_value;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    // output register drains and refills from the pending slot
    if (out_free) begin
      out_valid_d = 1'b0;
      if (pend_q) begin
        out_valid_d = 1'b1;
        out_res_d   = pend_res_q;
        pend_d      = 1'b0;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          pend_res_d.value      = '0;
          pend_res_d.final_flag = 1'b1;
          pend_res_d.status     = olst_pkg::ST_OK;
          unique case (olst_pkg::action_e'(req_i.action))
            olst_pkg::ACT_APPEND: begin
              pend_d = 1'b1;
              if (cnt_q >= DEPTH_CNT) begin
                pend_res_d.status = olst_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[AW-1:0];
                cnt_d     = cnt_q + ONE;
              end
            end
            olst_pkg::ACT_DUMP: begin
              if (list_empty) begin
                pend_d            = 1'b1;
                pend_res_d.status = olst_pkg::ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_d     = '0;
                state_d   = S_DUMP;
              end
            end
            olst_pkg::ACT_DEL_LAST: begin
              pend_d = 1'b1;
              if (list_empty) begin
                pend_res_d.status = olst_pkg::ST_EMPTY;
              end else begin
                cnt_d = cnt_m1;
              end
            end
            olst_pkg::ACT_DEL_FIRST, olst_pkg::ACT_DEL_AT: begin
              if (list_empty) begin
                pend_d            = 1'b1;
                pend_res_d.status = olst_pkg::ST_EMPTY;
              end else if ((olst_pkg::action_e'(req_i.action) == olst_pkg::ACT_DEL_AT)
                           && !pos_ok) begin
                pend_d            = 1'b1;
                pend_res_d.status = olst_pkg::ST_BAD_INDEX;
                pend_res_d.value  = {{(VAL_W-CNT_W){1'b0}}, cnt_m1};
              end else begin
                cnt_d = cnt_m1;
                if (rm_start == cnt_m1) begin
                  // removing the tail element, nothing to move
                  pend_d = 1'b1;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = rm_next[AW-1:0];
                  idx_d     = rm_start;
                  state_d   = S_SHIFT;
                end
              end
            end
            default: begin
              // unknown request: no response, no change
            end
          endcase
        end
      end

      S_DUMP: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_res_d.status     = olst_pkg::ST_OK;
          out_res_d.value      = ram_rdata;
          out_res_d.final_flag = idx_last;
          if (idx_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d     = idx_p1;
            ram_re    = 1'b1;
            ram_raddr = idx_p1[AW-1:0];
          end
        end else begin
          // hold the read of the current element while stalled
          ram_re    = 1'b1;
          ram_raddr = idx_q[AW-1:0];
        end
      end

      S_SHIFT: begin
        // move the element above down by one; count is already decremented
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        if (idx_last) begin
          pend_d                = 1'b1;
          pend_res_d.status     = olst_pkg::ST_OK;
          pend_res_d.value      = '0;
          pend_res_d.final_flag = 1'b1;
          state_d               = S_IDLE;
        end else begin
          idx_d     = idx_p1;
          ram_re    = 1'b1;
          ram_raddr = idx_p2[AW-1:0];
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    pend_res_q <= pend_res_d;
    out_res_q  <= out_res_d;
  end

  // response port
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_res_q.status;
  assign rsp_o.result_value = out_res_q.value;
  assign rsp_o.final_flag   = out_res_q.final_flag;

`ifndef ASSERT_OFF
  // the element count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_CNT)
    else $error("element count above capacity");

  // a shift never writes at or beyond the live part of the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (idx_q < cnt_q))
    else $error("shift write outside the list");

  // the last dump element returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dump_emit && idx_last) |=> (state_q == S_IDLE) && rsp_o.valid && rsp_o.final_flag)
    else $error("dump did not finish on its last element");

  // a dump never starts or runs with a result left in the pending slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> !pend_q)
    else $error("pending result during dump");
`endif

endmodule

`default_nettype wire
